// ===== rtl/core/ito_pkg.sv =====
// ----------------------------------------------------------------------------
// ito_pkg
// Shared types and constants of the incremental topological order block.
// ----------------------------------------------------------------------------
package ito_pkg;

    localparam int NODE_W          = 5;
    localparam int COUNT_W         = 12;
    localparam int CFG_W           = 6;
    localparam int STATUS_W        = 3;
    localparam int NUM_NODES_RESET = 26;
    localparam int NODE_ID_MAX     = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 12'hFFF;

    typedef enum logic [STATUS_W-1:0] {
        ST_CLEARED      = 3'd0,
        ST_UNDETERMINED = 3'd1,
        ST_INCONSISTENT = 3'd2,
        ST_DETERMINED   = 3'd3,
        ST_IGNORED      = 3'd4,
        ST_BAD          = 3'd5
    } status_t;

    typedef enum logic {
        CMD_CLEAR    = 1'b0,
        CMD_RELATION = 1'b1
    } command_t;

endpackage

// ===== rtl/core/incremental_topological_order.sv =====
// ----------------------------------------------------------------------------
// incremental_topological_order
// Folds precedence relations into an adjacency matrix and reruns a Kahn
// walk after each stored one, reporting undetermined / inconsistent / unique order.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake               payload
//  --------  ---  ----------------------  ------------------------------------
//  s_axis    in   s_axis_tvalid/tready    tuser: command
//                                         tdata: before_node, after_node
//  m_axis    out  m_axis_tvalid/tready    tuser: status, tlast: last
//                                         tdata: relation_count, order_node
//  cfg       in   cfg_valid/cfg_ready     cfg_data: num_nodes
//
//  Clear, bad-node and ignored requests go straight to a single result. A
//  stored relation first reads the rows of the n active nodes to build
//  in-degrees, then handles each placed node by an adjacency read and an
//  in-degree update, as set by the single read port of the adjacency
//  memory. A unique order replaces the single result by one result per
//  emitted node, each from an order buffer read and an output load.
//  Reset is asynchronous; row valid bits clear the matrix at once, so no
//  clearing pass is needed. Output stalls hold the walk only while emitting.
//
module incremental_topological_order #(
    parameter int MAX_NODES = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // config
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data,        // num_nodes
    // requests
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,    // [4:0] before_node, [9:5] after_node
    input  logic        s_axis_tuser,    // [0] command
    // results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,    // [11:0] relation_count, [16:12] order_node
    output logic [2:0]  m_axis_tuser,    // [2:0] status
    output logic        m_axis_tlast     // last
);

    // Active node limit; node ids are 5 bits wide so at most 32 nodes.
    localparam int NL = (MAX_NODES < ito_pkg::NODE_ID_MAX) ? MAX_NODES
                                                           : ito_pkg::NODE_ID_MAX;
    localparam int IW = $clog2(NL);       // row / node index
    localparam int CW = $clog2(NL + 1);   // counts up to NL

    typedef enum logic [3:0] {
        S_IDLE,
        S_WRITE,
        S_DEG,
        S_INIT,
        S_POP,
        S_UPD,
        S_FIN,
        S_EMIT1,
        S_EMIT_RD,
        S_EMIT_WR
    } state_t;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t                         state_reg;
    logic [ito_pkg::CFG_W-1:0]      num_nodes_reg;
    logic                           decided_reg;
    logic [ito_pkg::COUNT_W-1:0]    count_reg;
    logic [NL-1:0]                  row_valid_reg;
    logic                           adj_rvalid_reg;
    logic [IW-1:0]                  a_reg;
    logic [IW-1:0]                  b_reg;
    logic [CW-1:0]                  cnt_reg;      // degree-phase row counter
    logic                           rd_pend_reg;  // row read in flight
    logic [CW-1:0]                  deg_reg [NL]; // in-degree lanes
    logic [NL-1:0]                  pend_reg;     // enqueued, not yet popped
    logic [NL-1:0]                  placed_reg;
    logic                           unique_reg;
    logic [CW-1:0]                  head_reg;     // popped so far
    logic [CW-1:0]                  emit_idx_reg;
    ito_pkg::status_t               pend_status_reg;

    logic                           m_valid_reg;
    ito_pkg::status_t               m_status_reg;
    logic [ito_pkg::COUNT_W-1:0]    m_count_reg;
    logic [ito_pkg::NODE_W-1:0]     m_node_reg;
    logic                           m_last_reg;

    // memories: adjacency rows and order buffer, registered read
    logic [NL-1:0]                  adj_mem [NL];
    logic [NL-1:0]                  adj_rd_reg;
    logic [IW-1:0]                  order_mem [NL];
    logic [IW-1:0]                  order_rd_reg;

    // ------------------------------------------------------------------
    // Combinational
    // ------------------------------------------------------------------
    logic                           in_accept;
    ito_pkg::command_t              in_cmd;
    logic [ito_pkg::NODE_W-1:0]     in_before;
    logic [ito_pkg::NODE_W-1:0]     in_after;
    logic [ito_pkg::CFG_W-1:0]      n_act;
    logic [CW-1:0]                  n_cw;
    logic [NL-1:0]                  colmask;
    logic [NL-1:0]                  row_data;
    logic [NL-1:0]                  row_m;
    logic                           out_free;
    logic                           out_load;
    logic                           bad_node;
    logic [IW-1:0]                  adj_raddr;
    logic [IW-1:0]                  pop_idx;
    logic [NL-1:0]                  pop_onehot;
    logic                           pend_multi;
    logic [CW-1:0]                  deg_new [NL];
    logic [NL-1:0]                  new_ready;
    logic [NL-1:0]                  deg_zero;
    logic [NL-1:0]                  b_onehot;
    logic                           emit_last;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign in_cmd    = ito_pkg::command_t'(s_axis_tuser);
    assign in_before = s_axis_tdata[4:0];
    assign in_after  = s_axis_tdata[9:5];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;
    assign out_free      = !m_valid_reg || m_axis_tready;
    // output register loads a new result this cycle
    assign out_load      = out_free && ((state_reg == S_EMIT1) || (state_reg == S_EMIT_WR));

    // n saturated to 1..NL
    always_comb
    begin
        if (num_nodes_reg == '0)
            n_act = ito_pkg::CFG_W'(1);
        else if (num_nodes_reg > ito_pkg::CFG_W'(NL))
            n_act = ito_pkg::CFG_W'(NL);
        else
            n_act = num_nodes_reg;
    end
    assign n_cw = CW'(n_act);

    assign bad_node = ({1'b0, in_before} >= n_act) || ({1'b0, in_after} >= n_act);

    assign row_data  = adj_rvalid_reg ? adj_rd_reg : '0;
    assign row_m     = row_data & colmask;
    assign emit_last = (emit_idx_reg == n_cw - CW'(1));
    assign pend_multi = |(pend_reg & (pend_reg - NL'(1)));

    always_comb
    begin
        for (int i = 0; i < NL; i++)
        begin
            colmask[i]  = (CW'(i) < n_cw);
            deg_zero[i] = (deg_reg[i] == '0);
            b_onehot[i] = (b_reg == IW'(i));
            deg_new[i]  = deg_reg[i] - CW'(row_m[i] && !deg_zero[i]);
            new_ready[i] = row_m[i] && (deg_new[i] == '0) && !placed_reg[i];
        end
    end

    // lowest pending node
    always_comb
    begin
        pop_idx = '0;
        for (int i = NL - 1; i >= 0; i--)
        begin
            if (pend_reg[i])
                pop_idx = IW'(i);
        end
        pop_onehot = '0;
        pop_onehot[pop_idx] = 1'b1;
    end

    always_comb
    begin
        case (state_reg)
            S_IDLE:  adj_raddr = in_before[IW-1:0];
            S_DEG:   adj_raddr = cnt_reg[IW-1:0];
            S_POP:   adj_raddr = pop_idx;
            default: adj_raddr = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (state_reg == S_WRITE)
            adj_mem[a_reg] <= row_data | b_onehot;
        adj_rd_reg <= adj_mem[adj_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_POP && pend_reg != '0)
            order_mem[head_reg[IW-1:0]] <= pop_idx;
        order_rd_reg <= order_mem[emit_idx_reg[IW-1:0]];
    end

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            num_nodes_reg   <= ito_pkg::CFG_W'(ito_pkg::NUM_NODES_RESET);
            decided_reg     <= 1'b0;
            count_reg       <= '0;
            row_valid_reg   <= '0;
            adj_rvalid_reg  <= 1'b0;
            rd_pend_reg     <= 1'b0;
            a_reg           <= '0;
            b_reg           <= '0;
            cnt_reg         <= '0;
            for (int i = 0; i < NL; i++)
                deg_reg[i] <= '0;
            pend_reg        <= '0;
            placed_reg      <= '0;
            unique_reg      <= 1'b0;
            head_reg        <= '0;
            emit_idx_reg    <= '0;
            pend_status_reg <= ito_pkg::ST_CLEARED;
            m_valid_reg     <= 1'b0;
            m_status_reg    <= ito_pkg::ST_CLEARED;
            m_count_reg     <= '0;
            m_node_reg      <= '0;
            m_last_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                num_nodes_reg <= cfg_data;

            adj_rvalid_reg <= row_valid_reg[adj_raddr];

            if (m_valid_reg && m_axis_tready && !out_load)
                m_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        a_reg <= in_before[IW-1:0];
                        b_reg <= in_after[IW-1:0];
                        if (in_cmd == ito_pkg::CMD_CLEAR)
                        begin
                            row_valid_reg   <= '0;
                            decided_reg     <= 1'b0;
                            count_reg       <= '0;
                            pend_status_reg <= ito_pkg::ST_CLEARED;
                            state_reg       <= S_EMIT1;
                        end
                        else if (decided_reg)
                        begin
                            pend_status_reg <= ito_pkg::ST_IGNORED;
                            state_reg       <= S_EMIT1;
                        end
                        else if (bad_node)
                        begin
                            pend_status_reg <= ito_pkg::ST_BAD;
                            state_reg       <= S_EMIT1;
                        end
                        else
                        begin
                            state_reg <= S_WRITE;
                        end
                    end
                end

                S_WRITE:
                begin
                    row_valid_reg[a_reg] <= 1'b1;
                    if (count_reg != ito_pkg::COUNT_MAX)
                        count_reg <= count_reg + 1'b1;
                    cnt_reg     <= '0;
                    rd_pend_reg <= 1'b0;
                    for (int i = 0; i < NL; i++)
                        deg_reg[i] <= '0;
                    state_reg <= S_DEG;
                end

                S_DEG:
                begin
                    if (rd_pend_reg)
                    begin
                        for (int i = 0; i < NL; i++)
                            deg_reg[i] <= deg_reg[i] + CW'(row_m[i]);
                    end
                    if (cnt_reg < n_cw)
                    begin
                        cnt_reg     <= cnt_reg + CW'(1);
                        rd_pend_reg <= 1'b1;
                    end
                    else
                    begin
                        rd_pend_reg <= 1'b0;
                        if (!rd_pend_reg)
                            state_reg <= S_INIT;
                    end
                end

                S_INIT:
                begin
                    pend_reg   <= deg_zero & colmask;
                    placed_reg <= deg_zero & colmask;
                    unique_reg <= 1'b1;
                    head_reg   <= '0;
                    state_reg  <= S_POP;
                end

                S_POP:
                begin
                    if (pend_reg == '0)
                    begin
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        if (pend_multi)
                            unique_reg <= 1'b0;
                        pend_reg  <= pend_reg & ~pop_onehot;
                        head_reg  <= head_reg + CW'(1);
                        state_reg <= S_UPD;
                    end
                end

                S_UPD:
                begin
                    for (int i = 0; i < NL; i++)
                        deg_reg[i] <= deg_new[i];
                    pend_reg   <= pend_reg | new_ready;
                    placed_reg <= placed_reg | new_ready;
                    state_reg  <= S_POP;
                end

                S_FIN:
                begin
                    if (head_reg < n_cw)
                    begin
                        decided_reg     <= 1'b1;
                        pend_status_reg <= ito_pkg::ST_INCONSISTENT;
                        state_reg       <= S_EMIT1;
                    end
                    else if (unique_reg)
                    begin
                        decided_reg  <= 1'b1;
                        emit_idx_reg <= '0;
                        state_reg    <= S_EMIT_RD;
                    end
                    else
                    begin
                        pend_status_reg <= ito_pkg::ST_UNDETERMINED;
                        state_reg       <= S_EMIT1;
                    end
                end

                S_EMIT1:
                begin
                    if (out_free)
                    begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= pend_status_reg;
                        m_count_reg  <= count_reg;
                        m_node_reg   <= '0;
                        m_last_reg   <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end

                S_EMIT_RD:
                begin
                    state_reg <= S_EMIT_WR;
                end

                S_EMIT_WR:
                begin
                    if (out_free)
                    begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= ito_pkg::ST_DETERMINED;
                        m_count_reg  <= count_reg;
                        m_node_reg   <= ito_pkg::NODE_W'(order_rd_reg);
                        m_last_reg   <= emit_last;
                        if (emit_last)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            emit_idx_reg <= emit_idx_reg + CW'(1);
                            state_reg    <= S_EMIT_RD;
                        end
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_status_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tdata  = {7'd0, m_node_reg, m_count_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // only a unique order spans several results
    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && (m_status_reg != ito_pkg::ST_DETERMINED) |-> m_last_reg)
        else $error("non-order result without last mark");

    // a decided case stays decided until a clear request
    a_decided_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        decided_reg && !(in_accept && in_cmd == ito_pkg::CMD_CLEAR) |=> decided_reg)
        else $error("decided flag dropped without clear");

    // queued nodes are always marked placed during the walk
    a_pend_placed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POP || state_reg == S_UPD) |-> ((pend_reg & ~placed_reg) == '0))
        else $error("queued node not marked placed");

    // pops never exceed the active node count
    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) |-> (head_reg <= n_cw))
        else $error("walk placed more nodes than active");

endmodule
